### sv/lobt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobt_pkg
// shared types and constants of the order book table
// ----------------------------------------------------------------------------
package lobt_pkg;

  localparam int unsigned DEF_MAX_ORDERS = 256;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned LEVEL_W = 40;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

### sv/limit_order_book_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_table_top
// bounded order table; each item runs from accept to result in
// two passes over the slot memory: id/free search, then best/level scan
// one item at a time, one memory read per cycle sets the rate
// next item accepted in idle
// a result still waiting holds the next item in its last state
// reset clears slot valid flags and count at once; no clearing pass
// ----------------------------------------------------------------------------
module limit_order_book_table_top #(
  parameter int unsigned MAX_ORDERS = lobt_pkg::DEF_MAX_ORDERS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [lobt_pkg::ID_W-1:0]     in_order_id,
  input  logic                          in_side,
  input  logic [lobt_pkg::PRICE_W-1:0]  in_price,
  input  logic [lobt_pkg::QTY_W-1:0]    in_quantity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [lobt_pkg::PRICE_W-1:0]  out_best_bid,
  output logic                          out_bid_present,
  output logic [lobt_pkg::PRICE_W-1:0]  out_best_ask,
  output logic                          out_ask_present,
  output logic [lobt_pkg::COUNT_W-1:0]  out_order_count,
  output logic [lobt_pkg::LEVEL_W-1:0]  out_level_quantity
);
  import lobt_pkg::*;

  localparam int unsigned AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int unsigned CW = $clog2(MAX_ORDERS + 1);
  localparam int unsigned EW = ID_W + 1 + PRICE_W + QTY_W;
  localparam logic [AW:0] LAST = (AW+1)'(MAX_ORDERS - 1);

  logic [EW-1:0] mem [MAX_ORDERS];
  logic [EW-1:0] rd_data_r;
  logic [MAX_ORDERS-1:0] valid_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  state_t state_r, state_nxt;
  logic [AW:0]   addr_r, addr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  op_t           op_r;
  logic [ID_W-1:0]    id_r;
  logic               side_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  status_t       status_r, status_nxt;
  logic [PRICE_W-1:0] bid_r, bid_nxt, ask_r, ask_nxt;
  logic          hb_r, hb_nxt, ha_r, ha_nxt;
  logic [LEVEL_W:0] lvl_r, lvl_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic [1:0]         ostatus_r;
  logic [PRICE_W-1:0] obid_r, oask_r;
  logic               ohb_r, oha_r;
  logic [COUNT_W-1:0] ocount_r;
  logic [LEVEL_W-1:0] olvl_r;
  logic               out_ld;

  logic          wr_en, clr_en, set_en;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [ID_W-1:0]    e_id;
  logic               e_side;
  logic [PRICE_W-1:0] e_price;
  logic [QTY_W-1:0]   e_qty;
  logic               e_live;

  assign {e_id, e_side, e_price, e_qty} = rd_data_r;
  assign e_live = rd_vld_r && valid_r[rd_idx_r];
  assign rd_addr = addr_r[AW-1:0];

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[free_idx_r] <= {id_r, side_r, price_r, qty_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    rd_idx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      rd_vld_r <= rd_en;
      if (set_en) valid_r[free_idx_r] <= 1'b1;
      if (clr_en) valid_r[hit_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    hit_r <= hit_nxt; hit_idx_r <= hit_idx_nxt;
    free_r <= free_nxt; free_idx_r <= free_idx_nxt;
    status_r <= status_nxt;
    bid_r <= bid_nxt; ask_r <= ask_nxt; hb_r <= hb_nxt; ha_r <= ha_nxt;
    lvl_r <= lvl_nxt;
    if (in_valid && !in_stall) begin
      op_r    <= op_t'(in_operation);
      id_r    <= in_order_id;
      side_r  <= in_side;
      price_r <= in_price;
      qty_r   <= in_quantity;
    end
    if (out_ld) begin
      ostatus_r <= status_r;
      obid_r    <= bid_r;
      oask_r    <= ask_r;
      ohb_r     <= hb_r;
      oha_r     <= ha_r;
      ocount_r  <= (CW > COUNT_W && count_r > CW'(511)) ?
                   COUNT_W'(511) : COUNT_W'(count_r);
      olvl_r    <= lvl_r[LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    count_nxt = count_r;
    hit_nxt = hit_r; hit_idx_nxt = hit_idx_r;
    free_nxt = free_r; free_idx_nxt = free_idx_r;
    status_nxt = status_r;
    bid_nxt = bid_r; ask_nxt = ask_r; hb_nxt = hb_r; ha_nxt = ha_r;
    lvl_nxt = lvl_r;
    ovalid_nxt = ovalid_r && out_stall;
    out_ld = 1'b0;
    wr_en = 1'b0; set_en = 1'b0; clr_en = 1'b0;
    rd_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        addr_nxt = '0;
        hit_nxt = 1'b0; free_nxt = 1'b0;
        hit_idx_nxt = '0; free_idx_nxt = '0;
        if (in_valid && !in_stall) state_nxt = S_FIND;
      end
      S_FIND: begin
        // search pass: read one slot a cycle, check the one read last cycle
        rd_en = (addr_r <= LAST);
        if (addr_r <= LAST) addr_nxt = addr_r + 1'b1;
        if (rd_vld_r) begin
          if (e_live && e_id == id_r && !hit_r) begin
            hit_nxt = 1'b1; hit_idx_nxt = rd_idx_r;
          end
          if (!valid_r[rd_idx_r] && !free_r) begin
            free_nxt = 1'b1; free_idx_nxt = rd_idx_r;
          end
        end
        if (!rd_en && !rd_vld_r) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        status_nxt = ST_OK;
        if (op_r == OP_INSERT) begin
          if (hit_r) status_nxt = ST_DUPLICATE;
          else if (!free_r) status_nxt = ST_FULL;
          else begin
            wr_en = 1'b1; set_en = 1'b1; count_nxt = count_r + 1'b1;
          end
        end else if (op_r == OP_CANCEL) begin
          if (!hit_r) status_nxt = ST_NOT_FOUND;
          else begin
            clr_en = 1'b1; count_nxt = count_r - 1'b1;
          end
        end
        addr_nxt = '0;
        hb_nxt = 1'b0; ha_nxt = 1'b0; bid_nxt = '0; ask_nxt = '0;
        lvl_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rd_en = (addr_r <= LAST);
        if (addr_r <= LAST) addr_nxt = addr_r + 1'b1;
        if (e_live) begin
          if (!e_side) begin
            if (!hb_r || e_price > bid_r) bid_nxt = e_price;
            hb_nxt = 1'b1;
          end else begin
            if (!ha_r || e_price < ask_r) ask_nxt = e_price;
            ha_nxt = 1'b1;
          end
          if (e_side == side_r && e_price == price_r) begin
            lvl_nxt = lvl_r + (LEVEL_W+1)'(e_qty);
            if (lvl_nxt[LEVEL_W]) lvl_nxt = {1'b0, {LEVEL_W{1'b1}}};
          end
        end
        if (!rd_en && !rd_vld_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          out_ld = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = ovalid_r;
  assign out_status         = ostatus_r;
  assign out_best_bid       = obid_r;
  assign out_bid_present    = ohb_r;
  assign out_best_ask       = oask_r;
  assign out_ask_present    = oha_r;
  assign out_order_count    = ocount_r;
  assign out_level_quantity = olvl_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_r)))
    else $error("count mismatch");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_stall |=> ovalid_r && $stable(olvl_r) && $stable(ostatus_r))
    else $error("stalled result changed");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(set_en && clr_en))
    else $error("insert and cancel together");
endmodule

### tb/tb_limit_order_book_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_table_top
// self-checking bench for the order book table: a directed table of inserts,
// cancels and queries, a fill to full and drain, then random well-formed order
// flow with noise, each result compared against a behavioral book kept in the bench
// ----------------------------------------------------------------------------
module tb_limit_order_book_table_top;
  import lobt_pkg::*;

  localparam int NSLOT = DEF_MAX_ORDERS;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]         op;
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } order_item_t;

  typedef struct {
    logic [1:0]         status;
    logic [PRICE_W-1:0] bid;
    logic               bid_ok;
    logic [PRICE_W-1:0] ask;
    logic               ask_ok;
    logic [COUNT_W-1:0] count;
    logic [LEVEL_W-1:0] level;
  } book_result_t;

  typedef struct {
    order_item_t  item;
    logic         known;
    logic [1:0]   status;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_side;
  logic [1:0] in_operation;
  logic [ID_W-1:0] in_order_id;
  logic [PRICE_W-1:0] in_price;
  logic [QTY_W-1:0] in_quantity;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [PRICE_W-1:0] out_best_bid, out_best_ask;
  logic out_bid_present, out_ask_present;
  logic [COUNT_W-1:0] out_order_count;
  logic [LEVEL_W-1:0] out_level_quantity;

  limit_order_book_table_top dut (.*);

  // book model
  logic               bk_valid [NSLOT];
  logic [ID_W-1:0]    bk_id    [NSLOT];
  logic               bk_side  [NSLOT];
  logic [PRICE_W-1:0] bk_price [NSLOT];
  logic [QTY_W-1:0]   bk_qty   [NSLOT];
  int                 bk_live;

  book_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  int errors = 0;
  int wdog = 0;
  bit stim_done = 0;

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < NSLOT; i++) if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic book_result_t apply_order(order_item_t it);
    book_result_t r;
    int s;
    logic [47:0] lvl;
    r = '{default: '0};
    r.status = ST_OK;
    lvl = 0;
    if (it.op == OP_INSERT) begin
      if (slot_of(it.id) >= 0) begin
        r.status = ST_DUPLICATE;
      end else begin
        s = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!bk_valid[i]) s = i;
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          bk_valid[s] = 1; bk_id[s] = it.id; bk_side[s] = it.side;
          bk_price[s] = it.price; bk_qty[s] = it.qty; bk_live++;
        end
      end
    end else if (it.op == OP_CANCEL) begin
      s = slot_of(it.id);
      if (s < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        bk_valid[s] = 0; bk_live--;
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (bk_valid[i]) begin
        if (!bk_side[i]) begin
          if (!r.bid_ok || bk_price[i] > r.bid) r.bid = bk_price[i];
          r.bid_ok = 1;
        end else begin
          if (!r.ask_ok || bk_price[i] < r.ask) r.ask = bk_price[i];
          r.ask_ok = 1;
        end
        if (bk_side[i] == it.side && bk_price[i] == it.price) lvl += bk_qty[i];
      end
    end
    r.level = (lvl > 48'hFF_FFFF_FFFF) ? '1 : lvl[LEVEL_W-1:0];
    r.count = (bk_live > 511) ? 9'd511 : bk_live[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sender
  task automatic send_item(order_item_t it);
    book_result_t r;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1; in_operation <= it.op; in_order_id <= it.id; in_side <= it.side;
    in_price <= it.price; in_quantity <= it.qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_order(it);
    pending_results = {pending_results, r};
    in_valid <= 0;
  endtask

  function automatic order_item_t mk(logic [1:0] op, logic [ID_W-1:0] id, logic sd,
                                     logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    order_item_t it;
    it.op = op; it.id = id; it.side = sd; it.price = p; it.qty = q;
    return it;
  endfunction

  task automatic add_row(order_item_t it, logic known, logic [1:0] st, int cnt);
    dir_row_t d;
    d.item = it; d.known = known; d.status = st; d.count = cnt[COUNT_W-1:0];
    dir_rows = {dir_rows, d};
  endtask

  logic [ID_W-1:0] live_ids[$];

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return 32'd1000 + $urandom_range(0, 12);
    endcase
  endfunction

  initial begin
    order_item_t it;
    dir_row_t d;
    book_result_t want;
    int k;
    rst_n = 0; in_valid = 0; in_operation = 0; in_order_id = 0; in_side = 0;
    in_price = 0; in_quantity = 0;
    for (int i = 0; i < NSLOT; i++) begin
      bk_valid[i] = 0; bk_id[i] = 0; bk_side[i] = 0; bk_price[i] = 0; bk_qty[i] = 0;
    end
    bk_live = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(mk(OP_QUERY, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(OP_CANCEL, 64'd5, 1, 0, 0), 1, ST_NOT_FOUND, 0);
    add_row(mk(OP_INSERT, '0, 0, '1, '1), 1, ST_OK, 1);
    add_row(mk(OP_INSERT, '0, 1, 0, 1), 1, ST_DUPLICATE, 1);
    add_row(mk(OP_INSERT, '1, 1, '0, '1), 1, ST_OK, 2);
    add_row(mk(OP_INSERT, 64'hAAAA_5555_AAAA_5555, 0, '1, '1), 1, ST_OK, 3);
    add_row(mk(OP_INSERT, 64'h5555_AAAA_5555_AAAA, 1, '0, 32'h0), 1, ST_OK, 4);
    add_row(mk(OP_QUERY, 0, 0, '1, 0), 0, 0, 0);
    add_row(mk(OP_SPARE, '1, 1, '0, '1), 0, 0, 0);
    add_row(mk(OP_CANCEL, '0, 1, '0, 0), 1, ST_OK, 3);
    add_row(mk(OP_CANCEL, '0, 0, '1, 0), 1, ST_NOT_FOUND, 3);
    add_row(mk(OP_CANCEL, '1, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_CANCEL, 64'hAAAA_5555_AAAA_5555, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_CANCEL, 64'h5555_AAAA_5555_AAAA, 1, 0, 0), 1, ST_OK, 0);
    add_row(mk(OP_QUERY, 0, 1, 0, 0), 0, 0, 0);
    while (dir_rows.size() > 0) begin
      d = dir_rows.pop_front();
      send_item(d.item);
      if (d.known) begin
        want = pending_results[$];
        if (want.status != d.status)
          report_mismatch("table status", 64'(want.status), 64'(d.status));
        if (want.count != d.count)
          report_mismatch("table count", 64'(want.count), 64'(d.count));
      end
    end

    // fill the table to full, probe full and duplicate, then drain
    for (int i = 0; i < NSLOT; i++) begin
      it = mk(OP_INSERT, {32'hF111, i[31:0]}, i[0], 32'd2000 + i % 4, $urandom());
      send_item(it);
    end
    send_item(mk(OP_INSERT, 64'h1234, 0, 7, 7));
    send_item(mk(OP_INSERT, {32'hF111, 32'd3}, 0, 7, 7));
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    for (int i = 0; i < NSLOT; i++) send_item(mk(OP_CANCEL, {32'hF111, i[31:0]}, 0, 2000, 0));

    // random flow
    for (int n = 0; n < 120; n++) begin
      if (n == 60) begin
        wait (pending_results.size() == 0);
      end
      k = $urandom_range(0, 99);
      if (k < 45 && live_ids.size() < 200) begin
        it = mk(OP_INSERT, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)), rand_price(),
                ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 1000));
        if ($urandom_range(0, 9) == 0 && live_ids.size() > 0)
          it.id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else if (slot_of(it.id) < 0) live_ids = {live_ids, it.id};
      end else if (k < 75 && live_ids.size() > 0) begin
        k = $urandom_range(0, live_ids.size() - 1);
        it = mk(OP_CANCEL, live_ids[k], 1'($urandom_range(0, 1)), rand_price(), $urandom());
        live_ids.delete(k);
      end else if (k < 80) begin
        it = mk(OP_CANCEL, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
                rand_price(), 0);
      end else begin
        it = mk(2'($urandom_range(2, 3)), {$urandom(), $urandom()},
                1'($urandom_range(0, 1)), rand_price(), $urandom());
      end
      send_item(it);
    end
    stim_done = 1;
  end

  // receiver
  initial begin
    int hold;
    hold = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 49) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(10, 60);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'($urandom_range(0, 1));
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    book_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 64'd1, 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_status != e.status)
          report_mismatch("status", 64'(out_status), 64'(e.status));
        if (out_best_bid != e.bid)
          report_mismatch("best_bid", 64'(out_best_bid), 64'(e.bid));
        if (out_bid_present != e.bid_ok)
          report_mismatch("bid_present", 64'(out_bid_present), 64'(e.bid_ok));
        if (out_best_ask != e.ask)
          report_mismatch("best_ask", 64'(out_best_ask), 64'(e.ask));
        if (out_ask_present != e.ask_ok)
          report_mismatch("ask_present", 64'(out_ask_present), 64'(e.ask_ok));
        if (out_order_count != e.count)
          report_mismatch("order_count", 64'(out_order_count), 64'(e.count));
        if (out_level_quantity != e.level)
          report_mismatch("level_quantity", 64'(out_level_quantity), 64'(e.level));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
  end

  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (wdog >= WDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
